// ----- hdl/rrts_pkg.sv -----
`default_nettype none

package rrts_pkg;

    // Ring and semaphore sizes
    localparam int THREADS    = 6;
    localparam int SEMAPHORES = 4;

    localparam int THR_W     = $clog2(THREADS);
    localparam int SEM_IDX_W = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

    // Fixed field widths
    localparam int SLEEP_W    = 16;
    localparam int SEM_FLD_W  = 2;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0]        SLOW_PERIOD_RESET = 16'd100;
    localparam logic signed [15:0] SEM_MAX           = 16'sh7FFF;
    localparam logic signed [15:0] SEM_MIN           = 16'sh8000;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SLICE  = 3'd1,
        OP_SLEEP  = 3'd2,
        OP_WAIT   = 3'd3,
        OP_SIGNAL = 3'd4,
        OP_INIT   = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAST_EN     = 2'd0,
        REG_SLOW_EN     = 2'd1,
        REG_SLOW_PERIOD = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_SCHED,
        S_WAKE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]           operation;
        logic [SLEEP_W-1:0]   sleep_time;
        logic [SEM_FLD_W-1:0] semaphore;
        logic [14:0]          init_value;
    } in_t;

    typedef struct packed {
        logic [2:0]                running_thread;
        logic                      none_ready;
        logic                      fast_event;
        logic                      slow_event;
        logic                      woken_valid;
        logic [2:0]                woken_thread;
        logic signed [COUNT_W-1:0] semaphore_count;
    } out_t;

    // Control from the sequencer to the ring walker
    typedef struct packed {
        logic             start;
        logic             step;
        logic [THR_W-1:0] start_idx;
    } walk_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/round_robin_thread_scheduler_unit.sv -----
`default_nettype none

// Round-robin thread scheduler with counting semaphores.
// Input channel (in_valid/in_ready/in_data) takes one operation per beat:
// tick, time slice, sleep, wait, signal or semaphore init. Output channel
// (out_valid/out_ready/out_data) returns exactly one result beat per item.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 fast event
// enable, 1 slow event enable, 2 slow period); write only while idle.
// Timing: one item at a time. Ops with no thread walk go from acceptance
// through the execute state to the done state, which loads the output
// register. Tick, time slice, sleep, blocking wait and a signal that leaves
// the count at or below zero walk the ring one thread per cycle through the
// shared walker between those two states.
// A finished result sits in the output register; in_ready returns while it
// waits, so one more item can be worked on. If the receiver still stalls at
// the end of that item, the block holds and in_ready stays low.
// Reset clears all thread, semaphore and tick state, running thread 0,
// both event enables 0 and slow period 100.
module round_robin_thread_scheduler_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire rrts_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output rrts_pkg::out_t                        out_data,
    input  wire logic                             cfg_we,
    input  wire logic [rrts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rrts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rrts_pkg::*;

    state_t state_reg;
    state_t state_next;

    in_t  in_reg;
    out_t res_reg;
    out_t out_reg;
    logic out_valid_reg;

    logic        fast_en_reg;
    logic        slow_en_reg;
    logic [15:0] slow_period_reg;
    logic [15:0] tick_cnt_reg;

    logic [THR_W-1:0]     cur_reg;
    logic [SLEEP_W-1:0]   sleep_left_reg [THREADS];
    logic [THREADS-1:0]   blocked_reg;
    logic [SEM_FLD_W-1:0] blocked_on_reg [THREADS];
    logic signed [15:0]   sem_reg [SEMAPHORES];

    walk_ctrl_t       walk;
    logic [THR_W-1:0] walk_idx;
    logic             walk_last;

    op_t                op;
    logic               sem_ok;
    logic [SEM_IDX_W-1:0] sem_idx;
    logic signed [15:0] sem_new;
    logic               thread_ready;
    logic               wake_hit;
    logic [15:0]        tick_inc;
    logic [THR_W-1:0]   cur_inc;
    logic               accept;
    logic               finish;

    assign op       = op_t'(in_reg.operation);
    assign sem_ok   = (int'(in_reg.semaphore) < SEMAPHORES);
    assign sem_idx  = SEM_IDX_W'(in_reg.semaphore);
    assign tick_inc = tick_cnt_reg + 16'd1;
    assign cur_inc  = (cur_reg == THR_W'(THREADS - 1)) ? '0 : cur_reg + THR_W'(1);

    // Per-thread tests at the walker position
    assign thread_ready = (sleep_left_reg[walk_idx] == '0) && !blocked_reg[walk_idx];
    assign wake_hit     = blocked_reg[walk_idx] &&
                          (blocked_on_reg[walk_idx] == in_reg.semaphore);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    rrts_ring_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (walk),
        .idx   (walk_idx),
        .last  (walk_last)
    );

    rrts_sem_alu u_sem_alu (
        .operation  (op),
        .value      (sem_reg[sem_idx]),
        .init_value (in_reg.init_value),
        .result     (sem_new)
    );

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and walker control
    always_comb
    begin
        state_next     = state_reg;
        walk.start     = 1'b0;
        walk.step      = 1'b0;
        walk.start_idx = cur_inc;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op)
                    OP_TICK:
                    begin
                        walk.start     = 1'b1;
                        walk.start_idx = '0;
                        state_next     = S_TICK;
                    end
                    OP_SLICE, OP_SLEEP:
                    begin
                        walk.start = 1'b1;
                        state_next = S_SCHED;
                    end
                    OP_WAIT:
                    begin
                        if (sem_ok && sem_new[15])
                        begin
                            walk.start = 1'b1;
                            state_next = S_SCHED;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    OP_SIGNAL:
                    begin
                        if (sem_ok && (sem_new[15] || sem_new == 16'sd0))
                        begin
                            walk.start = 1'b1;
                            state_next = S_WAKE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TICK:
            begin
                walk.step = 1'b1;
                if (walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCHED:
            begin
                if (thread_ready || walk_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    walk.step = 1'b1;
                end
            end
            S_WAKE:
            begin
                if (wake_hit || walk_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    walk.step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_en_reg     <= 1'b0;
            slow_en_reg     <= 1'b0;
            slow_period_reg <= SLOW_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FAST_EN:     fast_en_reg     <= cfg_data[0];
                REG_SLOW_EN:     slow_en_reg     <= cfg_data[0];
                REG_SLOW_PERIOD: slow_period_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Scheduler state: threads, semaphores, tick counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            tick_cnt_reg <= '0;
            blocked_reg  <= '0;
            for (int i = 0; i < THREADS; i++)
            begin
                sleep_left_reg[i] <= '0;
                blocked_on_reg[i] <= '0;
            end
            for (int s = 0; s < SEMAPHORES; s++)
            begin
                sem_reg[s] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_EXEC:
                begin
                    case (op)
                        OP_TICK:
                        begin
                            tick_cnt_reg <= (tick_inc >= slow_period_reg) ? '0 : tick_inc;
                        end
                        OP_SLEEP:
                        begin
                            sleep_left_reg[cur_reg] <= in_reg.sleep_time;
                        end
                        OP_WAIT, OP_SIGNAL, OP_INIT:
                        begin
                            if (sem_ok)
                            begin
                                sem_reg[sem_idx] <= sem_new;
                                if (op == OP_WAIT && sem_new[15])
                                begin
                                    blocked_reg[cur_reg]    <= 1'b1;
                                    blocked_on_reg[cur_reg] <= in_reg.semaphore;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_TICK:
                begin
                    if (sleep_left_reg[walk_idx] != '0)
                    begin
                        sleep_left_reg[walk_idx] <= sleep_left_reg[walk_idx] - 16'd1;
                    end
                end
                S_SCHED:
                begin
                    if (thread_ready)
                    begin
                        cur_reg <= walk_idx;
                    end
                end
                S_WAKE:
                begin
                    if (wake_hit)
                    begin
                        blocked_reg[walk_idx]    <= 1'b0;
                        blocked_on_reg[walk_idx] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Input capture and result assembly
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg  <= in_data;
            res_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_EXEC:
                begin
                    if (op == OP_TICK)
                    begin
                        res_reg.fast_event <= fast_en_reg;
                        res_reg.slow_event <= slow_en_reg && (tick_cnt_reg == '0);
                    end
                    else if ((op == OP_WAIT || op == OP_SIGNAL || op == OP_INIT) && sem_ok)
                    begin
                        res_reg.semaphore_count <= sem_new;
                    end
                end
                S_SCHED:
                begin
                    if (!thread_ready && walk_last)
                    begin
                        res_reg.none_ready <= 1'b1;
                    end
                end
                S_WAKE:
                begin
                    if (wake_hit)
                    begin
                        res_reg.woken_valid  <= 1'b1;
                        res_reg.woken_thread <= 3'(walk_idx);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_reg                <= res_reg;
            out_reg.running_thread <= 3'(cur_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_tick_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) && walk_last |=> (state_reg == S_DONE))
        else $error("tick walk did not finish on last thread");

    a_sched_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCHED) && thread_ready |=> (cur_reg == $past(walk_idx)))
        else $error("reschedule did not take the ready thread");

    a_none_ready_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.none_ready |-> !out_data.woken_valid)
        else $error("none_ready and woken_valid in one result");

    a_running_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_data.running_thread) < THREADS))
        else $error("running thread outside the ring");

endmodule

`default_nettype wire

// ----- hdl/rrts_ring_walker.sv -----
`default_nettype none

// Steps one thread index per cycle around the ring while step is held; flags the last one.
module rrts_ring_walker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rrts_pkg::walk_ctrl_t     ctrl,
    output logic [rrts_pkg::THR_W-1:0]    idx,
    output logic                          last
);
    import rrts_pkg::*;

    logic [THR_W-1:0] idx_reg;
    logic [THR_W-1:0] cnt_reg;
    logic [THR_W-1:0] idx_inc;

    // Ring increment with wrap
    assign idx_inc = (idx_reg == THR_W'(THREADS - 1)) ? '0 : idx_reg + THR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctrl.start)
        begin
            idx_reg <= ctrl.start_idx;
            cnt_reg <= THR_W'(THREADS - 1);
        end
        else if (ctrl.step)
        begin
            idx_reg <= idx_inc;
            cnt_reg <= cnt_reg - THR_W'(1);
        end
    end

    assign idx  = idx_reg;
    assign last = (cnt_reg == '0);

endmodule

`default_nettype wire

// ----- hdl/rrts_sem_alu.sv -----
`default_nettype none

// Semaphore update: saturating decrement, saturating increment or load; other ops pass the value through.
module rrts_sem_alu (
    input  wire rrts_pkg::op_t            operation,
    input  wire logic signed [15:0]       value,
    input  wire logic [14:0]              init_value,
    output logic signed [15:0]            result
);
    import rrts_pkg::*;

    always_comb
    begin
        case (operation)
            OP_WAIT:   result = (value == SEM_MIN) ? value : value - 16'sd1;
            OP_SIGNAL: result = (value == SEM_MAX) ? value : value + 16'sd1;
            OP_INIT:   result = signed'({1'b0, init_value});
            default:   result = value;
        endcase
    end

endmodule

`default_nettype wire
